// ===== hw/rtl/double_ended_queue_unit_assert.svh =====
// Assertion macros for the deque unit; clocked on clk, disabled while rst_n is low.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define DEQ_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DEQ_ASSERT_ALWAYS(label, expr, msg)
`define DEQ_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/deq_pkg.sv =====
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_FRONT = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         occupancy;
  } out_t;

  // Broadcast to every cell in the row
  typedef struct packed {
    logic              push_front;
    logic              pop_front;
    logic              push_rear;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/deq_cell.sv =====
module deq_cell (
  input  logic                      clk,
  input  deq_pkg::cell_ctrl_t       ctrl,
  input  logic [deq_pkg::CNT_W-1:0] cell_idx,
  input  logic [deq_pkg::DATA_W-1:0] left_word,
  input  logic [deq_pkg::DATA_W-1:0] right_word,
  output logic [deq_pkg::DATA_W-1:0] word,
  output logic [deq_pkg::DATA_W-1:0] tail_word
);
  import deq_pkg::*;

  logic [DATA_W-1:0] word_r;
  logic [DATA_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctrl.push_front) begin
      word_nxt = left_word;
    end else if (ctrl.pop_front) begin
      word_nxt = right_word;
    end else if (ctrl.push_rear && (ctrl.count == cell_idx)) begin
      word_nxt = ctrl.value;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;
  // Only the rearmost occupied cell contributes to the rear-pop reduction
  assign tail_word = (ctrl.count == cell_idx + CNT_W'(1)) ? word_r : '0;

endmodule

// ===== hw/rtl/double_ended_queue_unit.sv =====
// Deque of signed 32-bit words held in a row of shifting cells, front word in cell 0.
// out_strobe is registered and rises in the cycle after start; throughput one word per cycle, busy stays low.
// Front push/pop shift the whole row by one cell; rear push writes the cell at the count.
// Reset (rst_n low, synchronous) empties the queue and clears the result strobe.
// The receiver cannot stall: each result is shown for exactly one cycle.
module double_ended_queue_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  deq_pkg::in_t  in_data,
  output logic          out_strobe,
  output deq_pkg::out_t out_data
);
  import deq_pkg::*;

  logic              accept;
  logic              is_push;
  logic              full;
  logic              empty;
  cell_ctrl_t        ctrl;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_strobe_r;
  out_t              out_r;
  out_t              out_nxt;
  logic [DATA_W-1:0] cell_word [DEPTH];
  logic [DATA_W-1:0] cell_tail [DEPTH];
  logic [DATA_W-1:0] rear_word;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_push = (in_data.func == OP_PUSH_REAR) || (in_data.func == OP_PUSH_FRONT);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);

  always_comb begin
    ctrl.push_front = accept && (in_data.func == OP_PUSH_FRONT) && !full;
    ctrl.pop_front  = accept && (in_data.func == OP_POP_FRONT) && !empty;
    ctrl.push_rear  = accept && (in_data.func == OP_PUSH_REAR) && !full;
    ctrl.value      = in_data.push_value;
    ctrl.count      = count_r;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_word;
    logic [DATA_W-1:0] right_word;
    if (i == 0) begin : g_head
      assign left_word = in_data.push_value;
    end else begin : g_body
      assign left_word = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_inner
      assign right_word = cell_word[i+1];
    end
    deq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_idx   (CNT_W'(i)),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (cell_word[i]),
      .tail_word  (cell_tail[i])
    );
  end

  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | cell_tail[i];
    end
  end

  always_comb begin
    count_nxt         = count_r;
    out_nxt.pop_value = '0;
    out_nxt.status    = ST_OK;
    if (is_push) begin
      if (full) begin
        out_nxt.status = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (empty) begin
      out_nxt.pop_value = '1;
      out_nxt.status    = ST_EMPTY;
    end else begin
      out_nxt.pop_value = (in_data.func == OP_POP_FRONT) ? cell_word[0] : rear_word;
      count_nxt         = count_r - CNT_W'(1);
    end
    out_nxt.occupancy = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

`include "double_ended_queue_unit_assert.svh"

  `DEQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH), "count beyond depth")
  `DEQ_ASSERT_NEXT(a_strobe_only_after_accept, !accept, !out_strobe_r, "stray result strobe")
  `DEQ_ASSERT_NEXT(a_push_grows, accept && is_push && !full,
                   out_strobe_r && (out_r.occupancy == count_r) && (out_r.status == ST_OK),
                   "push did not grow the queue")
  `DEQ_ASSERT_NEXT(a_empty_pop, accept && !is_push && empty,
                   (out_r.status == ST_EMPTY) && (out_r.pop_value == '1) && (count_r == '0),
                   "empty pop mishandled")

endmodule

// ===== verif/double_ended_queue_unit_checker.sv =====
`timescale 1ns / 1ps

module double_ended_queue_unit_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  deq_pkg::in_t  in_data,
  input  logic          out_strobe,
  input  deq_pkg::out_t out_data,
  output int            mismatches,
  output int            replies_due
);
  import deq_pkg::*;

  // Shadow deque: circular store, head position and fill level
  logic signed [DATA_W-1:0] slots [DEPTH];
  int                       head;
  int                       fill;
  out_t                     due_replies [$];
  out_t                     want;

  initial begin
    mismatches  = 0;
    replies_due = 0;
    head        = 0;
    fill        = 0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t deque check: %s", $time, what);
  endtask

  function automatic out_t deque_apply(input in_t w);
    out_t r;
    op_t  op;
    op          = op_t'(w.func);
    r.pop_value = '0;
    r.status    = ST_OK;
    case (op)
      OP_PUSH_REAR, OP_PUSH_FRONT: begin
        if (fill == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_REAR) begin
            slots[(head + fill) % DEPTH] = w.push_value;
          end else begin
            head        = (head + DEPTH - 1) % DEPTH;
            slots[head] = w.push_value;
          end
          fill++;
        end
      end
      default: begin
        if (fill == 0) begin
          r.pop_value = -1;
          r.status    = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT) begin
            r.pop_value = slots[head];
            head        = (head + 1) % DEPTH;
          end else begin
            r.pop_value = slots[(head + fill - 1) % DEPTH];
          end
          fill--;
        end
      end
    endcase
    r.occupancy = fill[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      // reply for a word accepted at an earlier edge
      if (out_strobe) begin
        if (due_replies.size() == 0) begin
          report_mismatch("result word with no reply due");
        end else begin
          want = due_replies.pop_front();
          if (out_data.pop_value !== want.pop_value)
            report_mismatch($sformatf("pop_value %0d, want %0d",
                                      out_data.pop_value, want.pop_value));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      out_data.status, want.status));
          if (out_data.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d, want %0d",
                                      out_data.occupancy, want.occupancy));
        end
      end
      if (start && !busy)
        due_replies.push_back(deque_apply(in_data));
    end
    replies_due <= due_replies.size();
  end

endmodule

// ===== verif/double_ended_queue_unit_tb.sv =====
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;
  import deq_pkg::*;

  localparam int RANDOM_WORDS = 1100;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_strobe;
  out_t out_data;
  int   mismatches;
  int   replies_due;
  int   cycles;

  double_ended_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  double_ended_queue_unit_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .mismatches (mismatches),
    .replies_due(replies_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("double_ended_queue_unit: mismatch");
      $finish;
    end
  end

  // Presents one word, waits for it to be taken, then drops start for the given gap, if any
  task automatic send_word(input op_t op, input logic signed [DATA_W-1:0] v,
                           input int gap);
    in_t w;
    w.func       = op;
    w.push_value = v;
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int pick_gap(input bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(DATA_W-1){1'b1}}};
      1:       return {1'b1, {(DATA_W-1){1'b0}}};
      2:       return -1;
      3:       return 0;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int   bias;
    int   run_left;
    bit   no_idle;
    op_t  op;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pops, extreme values through both ends, wrap at the front
    send_word(OP_POP_FRONT,  0, 0);
    send_word(OP_POP_REAR,   -1, 1);
    send_word(OP_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}}, 0);
    send_word(OP_PUSH_REAR,  {1'b0, {(DATA_W-1){1'b1}}}, 0);
    send_word(OP_PUSH_FRONT, -1, 2);
    send_word(OP_PUSH_REAR,  0, 0);
    send_word(OP_POP_REAR,   0, 0);
    send_word(OP_POP_FRONT,  0, 0);
    send_word(OP_POP_REAR,   0, 0);
    send_word(OP_POP_FRONT,  0, 0);
    send_word(OP_POP_FRONT,  0, 0);
    // fill to capacity, then push on a full queue at both ends
    for (int i = 0; i < DEPTH; i++)
      send_word(i[0] ? OP_PUSH_FRONT : OP_PUSH_REAR, $urandom(), 0);
    send_word(OP_PUSH_REAR,  $urandom(), 0);
    send_word(OP_PUSH_FRONT, $urandom(), 3);

    // random: runs biased towards filling, draining, or neither
    run_left = 0;
    bias     = 0;
    no_idle  = 1'b0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(10, 50);
        bias     = $urandom_range(0, 2);
        no_idle  = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      case (bias)
        0:       op = ($urandom_range(0, 99) < 80) ?
                      ($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR) :
                      ($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR);
        1:       op = ($urandom_range(0, 99) < 80) ?
                      ($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR) :
                      ($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR);
        default: op = op_t'($urandom_range(0, 3));
      endcase
      send_word(op, pick_value(), pick_gap(no_idle));
    end
    start <= 1'b0;

    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("double_ended_queue_unit: match");
    end else begin
      $display("double_ended_queue_unit: mismatch");
    end
    $finish;
  end

endmodule
